// ===== src/c3d_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers of the curl3D transform.
package c3d_pkg;

    typedef logic signed [63:0] t_q64;

    typedef enum logic [1:0] {
        REG_CURL_X = 2'd0,
        REG_CURL_Y = 2'd1,
        REG_CURL_Z = 2'd2,
        REG_WEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] cz;
        logic signed [63:0] wt;
    } t_cfg;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    // Saturating 64-bit add; bit 64 of the result flags a clip.
    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? Q_MIN : Q_MAX)};
        end
        return {1'b0, s[63:0]};
    endfunction

    // Saturating 64-bit subtract; bit 64 flags a clip.
    function automatic logic [64:0] sat_sub(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? Q_MIN : Q_MAX)};
        end
        return {1'b0, s[63:0]};
    endfunction

    // Turns a magnitude product back into a rounded, saturated signed value.
    // Input is the 128-bit magnitude product and its sign; FB fraction bits.
    function automatic logic [64:0] mul_finish(input logic [127:0] mag,
                                               input logic neg,
                                               input int unsigned fb);
        logic [127:0] rnd;
        logic [127:0] sh;
        logic         n;
        rnd = mag + (128'd1 << (fb - 1));
        sh  = rnd >> fb;
        n   = neg && (sh != '0);
        if (sh[127:64] != '0 || (!n && sh[63]) || (n && sh[63] && sh[62:0] != '0)) begin
            return {1'b1, (n ? Q_MIN : Q_MAX)};
        end
        return {1'b0, (n ? -sh[63:0] : sh[63:0])};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

endpackage

// ===== src/curl3d_point_transform_unit.sv =====
// Top level of the curl3D point transform: config registers, datapath pipeline, output skid.
//
//  channel | direction | request content
//  --------+-----------+-----------------------------------------------------
//  s_axis  | in        | tdata: point_x, point_y, point_z, acc_x/y/z_in
//  m_axis  | out       | tdata: acc_x/y/z_out; tuser: zero_divisor, clipped
//  apb     | in        | curl_x, curl_y, curl_z, weight at 4*index (8*index above 32 bits)
//
// One request enters every cycle while s_axis_tready is high. A result passes through 46
// pipeline stages after its request is accepted, set mostly by the pipelined divider
// (4 quotient bits per stage over 128 dividend bits) and the three-stage multipliers on
// the chain r2 -> den -> r -> term, and is then registered into the output buffer. The whole
// pipeline advances together on an enable; a two-entry skid buffer at the output lets the
// pipeline keep flowing while one finished result waits, and the input stalls only
// when both entries are full. Reset clears valid bits and loads the registers with
// their reset values (weight = 1.0).
module curl3d_point_transform_unit #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // point_x, point_y, point_z, acc_x_in, acc_y_in, acc_z_in from bit 0 up
    input  logic [6*DATA_WIDTH-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // acc_x_out, acc_y_out, acc_z_out from bit 0 up
    output logic [3*DATA_WIDTH-1:0]   m_axis_tdata,
    // zero_divisor, clipped from bit 0 up
    output logic [1:0]                m_axis_tuser,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [(DATA_WIDTH > 32 ? 5 : 4)-1:0]   paddr,
    input  logic [(DATA_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
    output logic [(DATA_WIDTH > 32 ? 64 : 32)-1:0] prdata,
    output logic                      pready
);
    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned PW = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int unsigned AW = (DATA_WIDTH > 32) ? 5 : 4;
    localparam int unsigned LM = 3;            // multiplier latency
    localparam int unsigned LD = 128 / 4 + 1;  // divider latency
    // Stage plan, in order from the input:
    // S0 squares, S1 sums r2/c2 and cross terms, S2 r2*c2, S3 den sums,
    // S4 divide, S5 r select, S6 curl*r2 done early, S7 r*term, S8 finish.
    localparam int unsigned T_A  = LM + 1;
    localparam int unsigned T_B  = T_A + LM + 1;
    localparam int unsigned T_C  = T_B + LD + 1;
    localparam int unsigned T_D  = T_C + LM + 1;
    localparam int unsigned LAT  = T_D;

    // ---------------- configuration ----------------
    logic [DW-1:0] r_cx, r_cy, r_cz, r_wt;
    logic [1:0]    wr_idx;
    assign pready = 1'b1;
    assign wr_idx = paddr[AW-1 -: 2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_wt <= DW'(1) << FRAC_BITS;
        end else if (psel && penable && pwrite) begin
            unique case (c3d_pkg::t_reg_idx'(wr_idx))
                c3d_pkg::REG_CURL_X: r_cx <= pwdata[DW-1:0];
                c3d_pkg::REG_CURL_Y: r_cy <= pwdata[DW-1:0];
                c3d_pkg::REG_CURL_Z: r_cz <= pwdata[DW-1:0];
                c3d_pkg::REG_WEIGHT: r_wt <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (c3d_pkg::t_reg_idx'(wr_idx))
            c3d_pkg::REG_CURL_X: prdata = PW'(r_cx);
            c3d_pkg::REG_CURL_Y: prdata = PW'(r_cy);
            c3d_pkg::REG_CURL_Z: prdata = PW'(r_cz);
            default:             prdata = PW'(r_wt);
        endcase
    end

    c3d_pkg::t_cfg cfg;
    assign cfg.cx = 64'(signed'(r_cx));
    assign cfg.cy = 64'(signed'(r_cy));
    assign cfg.cz = 64'(signed'(r_cz));
    assign cfg.wt = 64'(signed'(r_wt));

    // ---------------- flow control ----------------
    logic           en;
    logic [LAT-1:0] r_vld;
    logic [1:0]     r_cnt;
    logic [3*DW+1:0] r_sk [2];
    logic [3*DW+1:0] res;

    // The pipeline advances while the skid buffer has a free entry for what leaves it.
    assign en = r_cnt != 2'd2;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input unpack ----------------
    logic signed [63:0] x, y, z;
    logic [3*DW-1:0]    acc_in, acc_d;
    assign x = 64'(signed'(s_axis_tdata[0*DW +: DW]));
    assign y = 64'(signed'(s_axis_tdata[1*DW +: DW]));
    assign z = 64'(signed'(s_axis_tdata[2*DW +: DW]));
    assign acc_in = s_axis_tdata[3*DW +: 3*DW];

    // ---------------- stage A: squares and cross terms ----------------
    logic signed [63:0] px, py, pz, qx, qy, qz, kx, ky, kz;
    logic [8:0]         ca;
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_px (.i_clk, .i_en(en), .i_a(x), .i_b(x),
        .o_p(px), .o_clip(ca[0]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_py (.i_clk, .i_en(en), .i_a(y), .i_b(y),
        .o_p(py), .o_clip(ca[1]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_pz (.i_clk, .i_en(en), .i_a(z), .i_b(z),
        .o_p(pz), .o_clip(ca[2]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_qx (.i_clk, .i_en(en), .i_a(cfg.cx), .i_b(cfg.cx),
        .o_p(qx), .o_clip(ca[3]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_qy (.i_clk, .i_en(en), .i_a(cfg.cy), .i_b(cfg.cy),
        .o_p(qy), .o_clip(ca[4]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_qz (.i_clk, .i_en(en), .i_a(cfg.cz), .i_b(cfg.cz),
        .o_p(qz), .o_clip(ca[5]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_kx (.i_clk, .i_en(en), .i_a(cfg.cx <<< 1), .i_b(x),
        .o_p(kx), .o_clip(ca[6]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_ky (.i_clk, .i_en(en), .i_a(cfg.cy <<< 1), .i_b(y),
        .o_p(ky), .o_clip(ca[7]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_kz (.i_clk, .i_en(en), .i_a(cfg.cz <<< 1), .i_b(z),
        .o_p(kz), .o_clip(ca[8]));

    logic [191:0] xyz_a;
    c3d_delay #(.W(192), .N(LM)) u_dxa (.i_clk, .i_en(en), .i_d({z, y, x}), .o_q(xyz_a));

    // Sums, registered at T_A.
    logic signed [63:0] r_r2, r_c2, r_kx, r_ky, r_kz;
    logic signed [63:0] r_xa, r_ya, r_za;
    logic               r_cla;
    logic [64:0]        s1, s2, s3, s4;
    assign s1 = c3d_pkg::sat_add(px, py);
    assign s2 = c3d_pkg::sat_add(s1[63:0], pz);
    assign s3 = c3d_pkg::sat_add(qx, qy);
    assign s4 = c3d_pkg::sat_add(s3[63:0], qz);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2  <= s2[63:0];
            r_c2  <= s4[63:0];
            r_kx  <= kx;
            r_ky  <= ky;
            r_kz  <= kz;
            r_xa  <= xyz_a[63:0];
            r_ya  <= xyz_a[127:64];
            r_za  <= xyz_a[191:128];
            r_cla <= (|ca) | s1[64] | s2[64] | s3[64] | s4[64];
        end
    end

    // ---------------- stage B: den, and curl*r2 in parallel ----------------
    logic signed [63:0] rc, mx, my, mz;
    logic [3:0]         cb;
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_rc (.i_clk, .i_en(en), .i_a(r_r2), .i_b(r_c2),
        .o_p(rc), .o_clip(cb[0]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_mx (.i_clk, .i_en(en), .i_a(cfg.cx), .i_b(r_r2),
        .o_p(mx), .o_clip(cb[1]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_my (.i_clk, .i_en(en), .i_a(cfg.cy), .i_b(r_r2),
        .o_p(my), .o_clip(cb[2]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_mz (.i_clk, .i_en(en), .i_a(cfg.cz), .i_b(r_r2),
        .o_p(mz), .o_clip(cb[3]));

    logic [192+192:0] side_b;
    c3d_delay #(.W(385), .N(LM)) u_dsb (.i_clk, .i_en(en),
        .i_d({r_cla, r_kz, r_ky, r_kx, r_za, r_ya, r_xa}), .o_q(side_b));

    logic [64:0] d1, d2, d3, d4, t1, t2, t3;
    always_comb begin
        d1 = c3d_pkg::sat_add(rc, side_b[192 +: 64]);
        d2 = c3d_pkg::sat_sub(d1[63:0], side_b[256 +: 64]);
        d3 = c3d_pkg::sat_add(d2[63:0], side_b[320 +: 64]);
        d4 = c3d_pkg::sat_add(d3[63:0], 64'sd1 <<< FRAC_BITS);
        t1 = c3d_pkg::sat_add(side_b[0 +: 64], mx);
        t2 = c3d_pkg::sat_sub(side_b[64 +: 64], my);
        t3 = c3d_pkg::sat_add(side_b[128 +: 64], mz);
    end

    logic signed [63:0] r_den, r_t1, r_t2, r_t3;
    logic               r_clb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= d4[63:0];
            r_t1  <= t1[63:0];
            r_t2  <= t2[63:0];
            r_t3  <= t3[63:0];
            r_clb <= side_b[384] | (|cb) | d1[64] | d2[64] | d3[64] | d4[64]
                     | t1[64] | t2[64] | t3[64];
        end
    end

    // ---------------- stage C: divide ----------------
    logic signed [63:0] q;
    logic               cq;
    c3d_div #(.FRAC_BITS(FRAC_BITS)) u_div (.i_clk, .i_en(en), .i_num(cfg.wt),
        .i_den(r_den), .o_q(q), .o_clip(cq));

    logic [192+3:0] side_c;
    c3d_delay #(.W(196), .N(LD)) u_dsc (.i_clk, .i_en(en),
        .i_d({r_den == '0, cfg.wt[63], cfg.wt != '0, r_clb, r_t3, r_t2, r_t1}),
        .o_q(side_c));

    logic signed [63:0] r_r, r_u1, r_u2, r_u3;
    logic               r_zd, r_clc;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u1 <= side_c[0 +: 64];
            r_u2 <= side_c[64 +: 64];
            r_u3 <= side_c[128 +: 64];
            r_zd <= side_c[195];
            if (side_c[195]) begin
                r_r   <= !side_c[193] ? '0 : (side_c[194] ? c3d_pkg::Q_MIN : c3d_pkg::Q_MAX);
                r_clc <= side_c[192] | side_c[193];
            end else begin
                r_r   <= q;
                r_clc <= side_c[192] | cq;
            end
        end
    end

    // ---------------- stage D: r * term and final sums ----------------
    logic signed [63:0] ox, oy, oz;
    logic [2:0]         cd;
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_ox (.i_clk, .i_en(en), .i_a(r_r), .i_b(r_u1),
        .o_p(ox), .o_clip(cd[0]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_oy (.i_clk, .i_en(en), .i_a(r_r), .i_b(r_u2),
        .o_p(oy), .o_clip(cd[1]));
    c3d_mul #(.FRAC_BITS(FRAC_BITS)) u_oz (.i_clk, .i_en(en), .i_a(r_r), .i_b(r_u3),
        .o_p(oz), .o_clip(cd[2]));

    logic [1:0] fl_d;
    c3d_delay #(.W(2), .N(LM)) u_dfl (.i_clk, .i_en(en), .i_d({r_clc, r_zd}), .o_q(fl_d));
    c3d_delay #(.W(3*DW), .N(LAT - 1)) u_dac (.i_clk, .i_en(en), .i_d(acc_in), .o_q(acc_d));

    logic signed [63:0] hi_lim, lo_lim;
    logic [3*DW-1:0]    fo;
    logic [2:0]         cf;
    assign hi_lim = 64'((64'sd1 <<< (DW - 1)) - 1);
    assign lo_lim = 64'(-hi_lim - 1);
    always_comb begin
        logic [64:0]        s;
        logic signed [63:0] v;
        logic signed [63:0] tm [3];
        tm[0] = ox;
        tm[1] = oy;
        tm[2] = oz;
        for (int k = 0; k < 3; k++) begin
            s     = c3d_pkg::sat_add(64'(signed'(acc_d[k*DW +: DW])), tm[k]);
            v     = s[63:0];
            cf[k] = s[64];
            if (v > hi_lim) begin
                v = hi_lim;
                cf[k] = 1'b1;
            end else if (v < lo_lim) begin
                v = lo_lim;
                cf[k] = 1'b1;
            end
            fo[k*DW +: DW] = v[DW-1:0];
        end
    end

    logic [3*DW+1:0] r_res;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= {fl_d[1] | (|cd) | (|cf), fl_d[0], fo};
        end
    end
    assign res = r_res;

    // ---------------- output skid buffer ----------------
    logic push, pop;
    assign push = en && r_vld[LAT-1];
    assign pop  = m_axis_tvalid && m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (push && (pop ? (r_cnt == 2'd1) : (r_cnt == 2'd0))) begin
            r_sk[0] <= res;
        end else if (pop) begin
            r_sk[0] <= r_sk[1];
        end
        if (push && !pop && r_cnt == 2'd1) begin
            r_sk[1] <= res;
        end
    end
    assign m_axis_tvalid = r_cnt != 2'd0;
    assign m_axis_tdata  = r_sk[0][3*DW-1:0];
    assign m_axis_tuser  = r_sk[0][3*DW +: 2];
endmodule

// ===== src/c3d_mul.sv =====
// Pipelined Q-format multiplier: 32x32 partial products, sum, then round and saturate.
module c3d_mul #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p,
    output logic               o_clip
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic         r_neg0, r_neg1;
    logic [127:0] r_mag;
    logic [63:0]  ua, ub;
    logic [64:0]  fin;

    assign ua  = c3d_pkg::mag64(i_a);
    assign ub  = c3d_pkg::mag64(i_b);
    assign fin = c3d_pkg::mul_finish(r_mag, r_neg1, FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
            r_p01  <= {32'd0, ua[31:0]} * {32'd0, ub[63:32]};
            r_p10  <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
            r_p11  <= {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
            r_neg0 <= i_a[63] ^ i_b[63];
            r_mag  <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                      + {r_p11, 64'd0};
            r_neg1 <= r_neg0;
            o_p    <= fin[63:0];
            o_clip <= fin[64];
        end
    end
endmodule

// ===== src/c3d_div.sv =====
// Pipelined restoring divider: (num << FRAC_BITS) / den, STEP quotient bits per stage.
module c3d_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic signed [63:0] o_q,
    output logic               o_clip
);
    localparam int unsigned STEP   = 4;
    localparam int unsigned NBITS  = 128;
    localparam int unsigned NSTAGE = NBITS / STEP;

    logic [127:0] r_n   [NSTAGE+1];
    logic [64:0]  r_rem [NSTAGE+1];
    logic [63:0]  r_d   [NSTAGE+1];
    logic         r_neg [NSTAGE+1];
    logic [127:0] q_fin;
    logic         n_fin;

    always_comb begin
        r_n[0]   = {64'd0, c3d_pkg::mag64(i_num)} << FRAC_BITS;
        r_rem[0] = '0;
        r_d[0]   = c3d_pkg::mag64(i_den);
        r_neg[0] = i_num[63] ^ i_den[63];
    end

    // Each stage shifts the dividend out and the quotient in at the low end.
    for (genvar s = 0; s < NSTAGE; s++) begin : g_st
        logic [127:0] nn;
        logic [64:0]  rr;
        always_comb begin
            nn = r_n[s];
            rr = r_rem[s];
            for (int k = 0; k < STEP; k++) begin
                rr = {rr[63:0], nn[127]};
                nn = {nn[126:0], 1'b0};
                if (rr >= {1'b0, r_d[s]}) begin
                    rr    = rr - {1'b0, r_d[s]};
                    nn[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= nn;
                r_rem[s+1] <= rr;
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign q_fin = r_n[NSTAGE];
    assign n_fin = r_neg[NSTAGE] && (q_fin != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (q_fin[127:64] != '0 || (!n_fin && q_fin[63])
                || (n_fin && q_fin[63] && q_fin[62:0] != '0)) begin
                o_q    <= n_fin ? c3d_pkg::Q_MIN : c3d_pkg::Q_MAX;
                o_clip <= 1'b1;
            end else begin
                o_q    <= n_fin ? 64'(-q_fin[63:0]) : q_fin[63:0];
                o_clip <= 1'b0;
            end
        end
    end
endmodule

// ===== src/c3d_delay.sv =====
// Fixed-length enabled delay line for side data that rides along the pipeline.
module c3d_delay #(
    parameter int unsigned W = 8,
    parameter int unsigned N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [N];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end
    assign o_q = r_tap[N-1];
endmodule

// ===== src/c3d_checker.sv =====
// Port-level checks of the curl3D transform, bound to the top level.
module c3d_checker #(
    parameter int unsigned DW = 32
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            s_axis_tready,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [3*DW-1:0] m_axis_tdata,
    input logic [1:0]      m_axis_tuser,
    input logic            pready
);
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
        else $error("unknown bits in an offered result");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind curl3d_point_transform_unit c3d_checker #(.DW(DATA_WIDTH)) u_c3d_checker (
    .i_clk, .i_rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .pready
);

// ===== tb/curl3d_point_transform_unit_tb.sv =====
// Self-checking testbench of the curl3D point transform: random points, stalls and register settings.
`timescale 1ns / 1ps

module curl3d_point_transform_unit_tb;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int N_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] az;
        logic signed [31:0] ay;
        logic signed [31:0] ax;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } t_point_req;

    typedef struct {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic        zdiv;
        logic        clip;
    } t_curl_result;

    // Independent fixed-point predictor. The saturating helpers raise the sticky clip flag.
    class curl_scoreboard;
        t_curl_result pending[$];
        longint cx, cy, cz, wt;
        bit clip;
        int errors;

        function void reset_regs();
            cx = 0; cy = 0; cz = 0; wt = 64'sd1 <<< FB;
        endfunction

        function longint sadd(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin clip = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
            if (s < -65'sh0_8000_0000_0000_0000) begin clip = 1; return 64'sh8000_0000_0000_0000; end
            return s[63:0];
        endfunction

        function longint ssub(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) - 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin clip = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
            if (s < -65'sh0_8000_0000_0000_0000) begin clip = 1; return 64'sh8000_0000_0000_0000; end
            return s[63:0];
        endfunction

        // Converts a sign and a magnitude back to 64 bits, saturating.
        function longint from_mag(bit neg, logic [127:0] m);
            if (m == 0) return 0;
            if (!neg && m > 128'h7FFF_FFFF_FFFF_FFFF) begin clip = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
            if (neg && m > 128'h8000_0000_0000_0000) begin clip = 1; return 64'sh8000_0000_0000_0000; end
            return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
        endfunction

        function logic [63:0] umag(longint a);
            return a < 0 ? 64'(-a) : 64'(a);
        endfunction

        // Product with rounding to nearest, ties away from zero.
        function longint qmul(longint a, longint b);
            logic [127:0] m;
            m = (128'(umag(a)) * 128'(umag(b)) + (128'd1 << (FB - 1))) >> FB;
            return from_mag((a < 0) != (b < 0), m);
        endfunction

        function longint qdiv(longint n, longint d);
            logic [127:0] q;
            q = (128'(umag(n)) << FB) / 128'(umag(d));
            return from_mag((n < 0) != (d < 0), q);
        endfunction

        function logic [31:0] clamp_out(longint acc, longint term);
            longint s;
            s = sadd(acc, term);
            if (s > 64'sd2147483647) begin clip = 1; s = 64'sd2147483647; end
            else if (s < -64'sd2147483648) begin clip = 1; s = -64'sd2147483648; end
            return s[31:0];
        endfunction

        // Works out the expected result of one accepted request.
        function void note_request(t_point_req q);
            longint x, y, z, r2, c2, den, r;
            t_curl_result e;
            x = q.px; y = q.py; z = q.pz;
            clip = 0;
            r2 = sadd(sadd(qmul(x, x), qmul(y, y)), qmul(z, z));
            c2 = sadd(sadd(qmul(cx, cx), qmul(cy, cy)), qmul(cz, cz));
            den = qmul(r2, c2);
            den = sadd(den, qmul(cx * 2, x));
            den = ssub(den, qmul(cy * 2, y));
            den = sadd(den, qmul(cz * 2, z));
            den = sadd(den, 64'sd1 <<< FB);
            e.zdiv = (den == 0);
            if (den == 0) begin
                if (wt > 0) begin r = 64'sh7FFF_FFFF_FFFF_FFFF; clip = 1; end
                else if (wt < 0) begin r = 64'sh8000_0000_0000_0000; clip = 1; end
                else r = 0;
            end else begin
                r = qdiv(wt, den);
            end
            e.ox = clamp_out(q.ax, qmul(r, sadd(x, qmul(cx, r2))));
            e.oy = clamp_out(q.ay, qmul(r, ssub(y, qmul(cy, r2))));
            e.oz = clamp_out(q.az, qmul(r, sadd(z, qmul(cz, r2))));
            e.clip = clip;
            pending.push_back(e);
        endfunction

        task check_result(logic [95:0] d, logic [1:0] u);
            t_curl_result e;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, d[31:0]);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.ox) report_mismatch("acc_x_out", e.ox, d[31:0]);
            if (d[63:32] !== e.oy) report_mismatch("acc_y_out", e.oy, d[63:32]);
            if (d[95:64] !== e.oz) report_mismatch("acc_z_out", e.oz, d[95:64]);
            if (u[0] !== e.zdiv) report_mismatch("zero_divisor", e.zdiv, u[0]);
            if (u[1] !== e.clip) report_mismatch("clipped", e.clip, u[1]);
        endtask

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [6*DW-1:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [3*DW-1:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    curl_scoreboard sb = new();
    longint cycles = 0;
    bit     calm = 0;     // in the closing stretch neither side idles

    curl3d_point_transform_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Runaway guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver side: random stall bursts, results checked on acceptance.
    initial begin : receiver
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 18);
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // One APB write: setup then access phase.
    task automatic write_reg(c3d_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            c3d_pkg::REG_CURL_X: sb.cx = longint'($signed(val));
            c3d_pkg::REG_CURL_Y: sb.cy = longint'($signed(val));
            c3d_pkg::REG_CURL_Z: sb.cz = longint'($signed(val));
            default:             sb.wt = longint'($signed(val));
        endcase
    endtask

    task automatic set_curl(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
        write_reg(c3d_pkg::REG_CURL_X, x);
        write_reg(c3d_pkg::REG_CURL_Y, y);
        write_reg(c3d_pkg::REG_CURL_Z, z);
        write_reg(c3d_pkg::REG_WEIGHT, w);
    endtask

    // Sends one request, holding valid until it is taken, with optional idle burst first.
    task automatic send_point(t_point_req q);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= q;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    // Mostly small coordinates, sometimes full-range ones.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_curl();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 0;
            default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    function automatic t_point_req rand_point();
        t_point_req q;
        q.px = rand_coord(); q.py = rand_coord(); q.pz = rand_coord();
        q.ax = $urandom_range(0, 3) == 0 ? $urandom() : rand_coord();
        q.ay = $urandom(); q.az = rand_coord();
        return q;
    endfunction

    initial begin : stimulus
        t_point_req q;
        logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        sb.reset_regs();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: defaults, field extremes and output overflow.
        foreach (ext[i]) begin
            q = '{az: ext[(i+1)%4], ay: ext[(i+2)%4], ax: ext[i], pz: ext[(i+3)%4],
                  py: ext[(i+1)%4], px: ext[i]};
            send_point(q);
        end
        send_point('{az: 32'h7FFF_0000, ay: 32'h8000_0000, ax: 32'h7FFF_FFFF,
                     pz: 32'h1_0000, py: 32'hFFFF_0000, px: 32'h1_0000});
        drain();
        // Zero denominator: cx = 1.0, x = -1 gives den = 0; try all weight signs.
        set_curl(32'h0001_0000, 0, 0, 32'h0002_0000);
        send_point('{az: 0, ay: 0, ax: 0, pz: 0, py: 0, px: 32'hFFFF_0000});
        drain();
        write_reg(c3d_pkg::REG_WEIGHT, 32'hFFFF_0000);
        send_point('{az: 0, ay: 32'h100, ax: 32'h7FFF_FFFF, pz: 0, py: 0, px: 32'hFFFF_0000});
        drain();
        write_reg(c3d_pkg::REG_WEIGHT, 0);
        send_point('{az: 5, ay: 0, ax: 0, pz: 0, py: 0, px: 32'hFFFF_0000});
        send_point(rand_point());
        drain();
        // Register extremes, which saturate the intermediates.
        set_curl(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++) send_point(rand_point());
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 12; ph++) begin
            // One phase sits on the zero-denominator setting with a random weight.
            if (ph == 6)
                set_curl(32'h0001_0000, 0, 0, $urandom());
            else
                set_curl(rand_curl(), rand_curl(), rand_curl(),
                         $urandom_range(0, 3) == 0 ? $urandom() : rand_curl());
            if (ph == 11) calm = 1;
            for (int i = 0; i < N_RANDOM / 12; i++) begin
                // Occasionally aim at den = 0 along x.
                if ($urandom_range(0, 40) == 0 && sb.cx == 32'h1_0000 && sb.cy == 0 && sb.cz == 0)
                    send_point('{az: $urandom(), ay: $urandom(), ax: $urandom(),
                                 pz: 0, py: 0, px: 32'hFFFF_0000});
                else
                    send_point(rand_point());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
